>>> rtl/core/mrf_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the request framer.
// No dependencies; imported by every module in rtl/core.
package mrf_pkg;

  localparam logic       CMD_READ   = 1'b0;
  localparam logic       CMD_WRITE  = 1'b1;
  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] READ_QUANTITY  = 16'h0001;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [IdxW-1:0] IDX_UNIT     = 3'd0;
  localparam logic [IdxW-1:0] IDX_FUNC     = 3'd1;
  localparam logic [IdxW-1:0] IDX_REG_HI   = 3'd2;
  localparam logic [IdxW-1:0] IDX_REG_LO   = 3'd3;
  localparam logic [IdxW-1:0] IDX_DATA_HI  = 3'd4;
  localparam logic [IdxW-1:0] IDX_DATA_LO  = 3'd5;
  localparam logic [IdxW-1:0] IDX_CRC_LO   = 3'd6;
  localparam logic [IdxW-1:0] IDX_CRC_HI   = 3'd7;

  // one classified request, ready to be serialized
  typedef struct packed {
    logic [7:0]  unit_addr;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [15:0] payload;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/core/mrf_front.sv
// Front end: holds the unit address register, accepts requests and classifies them.
// Depends on mrf_pkg; feeds mrf_queue.
module mrf_front import mrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_unit_address_i,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [15:0] register_address_i,
  input  logic [15:0] write_value_i,
  input  q_status_t   q_status_i,
  output logic        push_o,
  output req_t        push_req_o
);

  logic [7:0] unit_address_q, unit_address_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    unit_address_d = unit_address_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unit_address_d = cfg_unit_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_address_q <= 8'd1;
    end else begin
      unit_address_q <= unit_address_d;
    end
  end

  assign busy   = q_status_i.full;
  assign push_o = start && !busy;

  always_comb begin
    push_req_o.unit_addr = unit_address_q;
    push_req_o.reg_addr  = register_address_i;
    if (command_i == CMD_WRITE) begin
      push_req_o.func_code = FN_WRITE_SINGLE;
      push_req_o.payload   = write_value_i;
    end else begin
      // read always asks for one register
      push_req_o.func_code = FN_READ_HOLDING;
      push_req_o.payload   = READ_QUANTITY;
    end
  end

endmodule

>>> rtl/core/mrf_queue.sv
// Short request queue between front and back end.
// Depends on mrf_pkg for the entry and status types.
module mrf_queue import mrf_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  req_t      push_req_i,
  input  logic      pop_i,
  output req_t      head_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == DepthCnt);
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt) else $error("queue count out of range");
`endif

endmodule

>>> rtl/core/mrf_back.sv
// Back end: serializes the head request into eight frame bytes with a running CRC.
// Depends on mrf_pkg (crc_byte, frame byte indexes); reads from mrf_queue.
module mrf_back import mrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic       frame_valid_o,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);

  logic [IdxW-1:0] byte_idx_q, byte_idx_d;
  logic [15:0]     crc_q, crc_d;
  logic            valid_q, last_q;
  logic [7:0]      byte_q, cur_byte;
  logic            active;

  assign active = !q_status_i.empty;
  assign pop_o  = active && (byte_idx_q == IDX_CRC_HI);

  always_comb begin
    case (byte_idx_q)
      IDX_UNIT:    cur_byte = head_i.unit_addr;
      IDX_FUNC:    cur_byte = head_i.func_code;
      IDX_REG_HI:  cur_byte = head_i.reg_addr[15:8];
      IDX_REG_LO:  cur_byte = head_i.reg_addr[7:0];
      IDX_DATA_HI: cur_byte = head_i.payload[15:8];
      IDX_DATA_LO: cur_byte = head_i.payload[7:0];
      IDX_CRC_LO:  cur_byte = crc_q[7:0];
      IDX_CRC_HI:  cur_byte = crc_q[15:8];
      default:     cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    byte_idx_d = byte_idx_q;
    crc_d      = crc_q;
    if (active) begin
      byte_idx_d = byte_idx_q + 1'b1;  // wraps to zero after the crc high byte
      // crc covers the six header bytes, restarting on the first
      if (byte_idx_q == IDX_UNIT) begin
        crc_d = crc_byte(CRC_INIT, cur_byte);
      end else if (byte_idx_q <= IDX_DATA_LO) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
      valid_q    <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      byte_idx_q <= byte_idx_d;
      valid_q    <= active;
      last_q     <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    byte_q <= cur_byte;
  end

  assign frame_valid_o = valid_q;
  assign frame_byte_o  = byte_q;
  assign last_byte_o   = last_q;

`ifndef SYNTHESIS
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> frame_valid_o) else $error("last byte without strobe");
  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |=> !last_byte_o) else $error("adjacent last bytes");
  a_strobe_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> $past(!q_status_i.empty)) else $error("byte sent with empty queue");
`endif

endmodule

>>> rtl/core/modbus_rtu_request_framer_top.sv
// Top level of the Modbus RTU request framer.
// Depends on mrf_pkg, mrf_front, mrf_queue and mrf_back.
//
// Usage:
//   Requests enter on start/busy: a request is taken at a clock edge where
//   start is high and busy is low, with command_i (0 read one holding
//   register, 1 write single register), register_address_i and write_value_i.
//   The unit address register is written over cfg_valid_i/cfg_ready_o with
//   cfg_unit_address_i; cfg_ready_o is always high. It resets to 1.
//   Each request yields eight frame bytes on frame_byte_o, one per cycle,
//   marked by frame_valid_o; last_byte_o flags the crc high byte.
//   A taken request is written into the queue, then its bytes pass through
//   output registers; the back end emits one byte per cycle while the queue
//   is not empty; the crc is updated a byte per cycle as the header goes out.
//   A queue of QueueDepth requests lets new requests be taken while a frame
//   is still being sent; busy is high only while that queue is full.
//   The receiver cannot stall: every byte is shown for exactly one cycle.
//   Reset clears the queue and the byte counter and sets unit address to 1.
module modbus_rtu_request_framer_top import mrf_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_unit_address_i,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [15:0] register_address_i,
  input  logic [15:0] write_value_i,
  output logic        frame_valid_o,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);

  q_status_t q_status;
  logic      push, pop;
  req_t      push_req, head_req;

  mrf_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_unit_address_i (cfg_unit_address_i),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .register_address_i (register_address_i),
    .write_value_i      (write_value_i),
    .q_status_i         (q_status),
    .push_o             (push),
    .push_req_o         (push_req)
  );

  mrf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head_req),
    .status_o   (q_status)
  );

  mrf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_req),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .frame_valid_o (frame_valid_o),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for modbus_rtu_request_framer_top: random and directed requests
// against a frame predictor with its own crc-16/modbus. Depends on mrf_pkg and the rtl.
module tb_top;
  import mrf_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [15:0] reg_addr;
    logic [15:0] value;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_unit_address_i = 8'h00;
  logic        start = 1'b0;
  logic        busy;
  logic        command_i = CMD_READ;
  logic [15:0] register_address_i = 16'h0000;
  logic [15:0] write_value_i = 16'h0000;
  logic        frame_valid_o;
  logic [7:0]  frame_byte_o;
  logic        last_byte_o;

  request_t    queued_requests[$];
  frame_beat_t frame_bytes_due[$];
  request_t    next_req;
  frame_beat_t got_beat;
  logic [7:0]  unit_addr_model = 8'd1;
  logic [7:0]  cfg_write_value = 8'h00;
  bit          cfg_write_pending = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned err_count = 0;

  modbus_rtu_request_framer_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_unit_address_i (cfg_unit_address_i),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .register_address_i (register_address_i),
    .write_value_i      (write_value_i),
    .frame_valid_o      (frame_valid_o),
    .frame_byte_o       (frame_byte_o),
    .last_byte_o        (last_byte_o)
  );

  always #5 clk_i = ~clk_i;

  // expected eight bytes of one request, crc over the six header bytes, low byte first
  function automatic void queue_frame(request_t r);
    logic [7:0]  bytes_out [FrameLen];
    logic [15:0] payload;
    logic [15:0] crc;
    payload = (r.cmd == CMD_WRITE) ? r.value : READ_QUANTITY;
    bytes_out[0] = unit_addr_model;
    bytes_out[1] = (r.cmd == CMD_WRITE) ? FN_WRITE_SINGLE : FN_READ_HOLDING;
    bytes_out[2] = r.reg_addr[15:8];
    bytes_out[3] = r.reg_addr[7:0];
    bytes_out[4] = payload[15:8];
    bytes_out[5] = payload[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc ^ {8'h00, bytes_out[i]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    bytes_out[6] = crc[7:0];
    bytes_out[7] = crc[15:8];
    for (int k = 0; k < FrameLen; k++) begin
      frame_bytes_due.push_back('{data: bytes_out[k], last: (k == FrameLen - 1)});
    end
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.cmd      = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    r.reg_addr = 16'($urandom_range(0, 65535));
    r.value    = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  // request driver and config writer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start              <= 1'b0;
      command_i          <= CMD_READ;
      register_address_i <= 16'h0000;
      write_value_i      <= 16'h0000;
      cfg_valid_i        <= 1'b0;
      cfg_unit_address_i <= 8'h00;
      unit_addr_model    = 8'd1;
      frame_bytes_due.delete();
    end else begin
      if (start && !busy) begin
        queue_frame('{cmd: command_i, reg_addr: register_address_i, value: write_value_i});
      end
      // a request still waiting for busy to drop must hold
      if (!start || !busy) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_req = queued_requests.pop_front();
          start              <= 1'b1;
          command_i          <= next_req.cmd;
          register_address_i <= next_req.reg_addr;
          write_value_i      <= next_req.value;
        end else begin
          start <= 1'b0;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unit_addr_model   = cfg_unit_address_i;
        cfg_valid_i       <= 1'b0;
        cfg_write_pending = 1'b0;
      end else if (cfg_write_pending) begin
        cfg_valid_i        <= 1'b1;
        cfg_unit_address_i <= cfg_write_value;
      end
    end
  end

  // frame byte checker
  always @(posedge clk_i) begin
    if (rst_ni && frame_valid_o) begin
      if (frame_bytes_due.size() == 0) begin
        err_count++;
        $error("frame_byte: nothing expected, got %h (last_byte %b)", frame_byte_o, last_byte_o);
      end else begin
        got_beat = frame_bytes_due.pop_front();
        if (frame_byte_o !== got_beat.data) begin
          err_count++;
          $error("frame_byte: expected %h, got %h", got_beat.data, frame_byte_o);
        end
        if (last_byte_o !== got_beat.last) begin
          err_count++;
          $error("last_byte: expected %b, got %b", got_beat.last, last_byte_o);
        end
      end
    end
  end

  task automatic add_random_requests(int unsigned count);
    repeat (count) queued_requests.push_back(random_request());
  endtask

  task automatic wait_frames_done();
    @(negedge clk_i);
    while (queued_requests.size() != 0 || start || frame_bytes_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_unit_address(logic [7:0] addr);
    @(negedge clk_i);
    cfg_write_value   = addr;
    cfg_write_pending = 1'b1;
    while (cfg_write_pending) @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, both functions, read ignoring write_value
    sender_idle_pct = 37;
    queued_requests.push_back('{cmd: CMD_READ,  reg_addr: 16'h0000, value: 16'h0000});
    queued_requests.push_back('{cmd: CMD_READ,  reg_addr: 16'hFFFF, value: 16'hFFFF});
    queued_requests.push_back('{cmd: CMD_READ,  reg_addr: 16'hAAAA, value: 16'h1234});
    queued_requests.push_back('{cmd: CMD_READ,  reg_addr: 16'h5555, value: 16'h0001});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'h0000, value: 16'h0000});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'hFFFF, value: 16'hFFFF});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'h0000, value: 16'hFFFF});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'hFFFF, value: 16'h0000});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'h5555, value: 16'hAAAA});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'hAAAA, value: 16'h5555});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'h8000, value: 16'h0001});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'h0001, value: 16'h8000});
    queued_requests.push_back('{cmd: CMD_READ,  reg_addr: 16'h0001, value: 16'h8000});
    queued_requests.push_back('{cmd: CMD_READ,  reg_addr: 16'h8000, value: 16'h0000});
    add_random_requests(70);
    wait_frames_done();

    // broadcast address
    sender_idle_pct = 48;
    write_unit_address(8'h00);
    queued_requests.push_back('{cmd: CMD_READ,  reg_addr: 16'h0010, value: 16'hFFFF});
    queued_requests.push_back('{cmd: CMD_WRITE, reg_addr: 16'h0010, value: 16'hBEEF});
    add_random_requests(63);
    wait_frames_done();

    sender_idle_pct = 0;
    write_unit_address(8'hFF);
    add_random_requests(60);
    wait_frames_done();

    write_unit_address(8'($urandom_range(2, 254)));
    add_random_requests(55);
    wait_frames_done();

    repeat (4) @(posedge clk_i);
    if (err_count == 0 && frame_bytes_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mrf_pkg.sv
rtl/core/mrf_front.sv
rtl/core/mrf_queue.sv
rtl/core/mrf_back.sv
rtl/core/modbus_rtu_request_framer_top.sv
sim/tb_top.sv
